### rtl/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg: shared types and constants of the BMP pixel row decoder
// Request payload structs, register indexes and depth codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bpd_pkg;

    // Input request payload
    typedef struct packed {
        logic       opcode;
        logic [7:0] byte_value;
        logic       start_of_image;
        logic [7:0] palette_index;
        logic [7:0] palette_red;
        logic [7:0] palette_green;
        logic [7:0] palette_blue;
    } t_in_req;

    // Output request payload (one pixel)
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic        row_end;
        logic        last_of_item;
    } t_out_req;

    // Opcodes
    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_DEPTH_MODE    = 3'd0;
    localparam logic [2:0] REG_USE_BITFIELDS = 3'd1;
    localparam logic [2:0] REG_RED_MASK      = 3'd2;
    localparam logic [2:0] REG_GREEN_MASK    = 3'd3;
    localparam logic [2:0] REG_BLUE_MASK     = 3'd4;
    localparam logic [2:0] REG_ALPHA_MASK    = 3'd5;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd6;
    localparam logic [2:0] REG_PALETTE_COUNT = 3'd7;

    // Depth codes
    localparam logic [2:0] DEPTH_1  = 3'd0;
    localparam logic [2:0] DEPTH_4  = 3'd1;
    localparam logic [2:0] DEPTH_8  = 3'd2;
    localparam logic [2:0] DEPTH_16 = 3'd3;
    localparam logic [2:0] DEPTH_24 = 3'd4;
    localparam logic [2:0] DEPTH_32 = 3'd5;

    // Fixed 5-5-5 channel masks
    localparam logic [31:0] MASK_555_RED   = 32'h0000_7C00;
    localparam logic [31:0] MASK_555_GREEN = 32'h0000_03E0;
    localparam logic [31:0] MASK_555_BLUE  = 32'h0000_001F;

endpackage

`default_nettype wire

### rtl/bmp_pixel_row_decoder.sv
// ----------------------------------------------------------------------------
// bmp_pixel_row_decoder: BMP pixel array bytes to RGBA8888 pixels
// Palette store, byte assembler, row/column tracking and one shared
// sequential divider for mask scaling.
// ----------------------------------------------------------------------------
// Accepts one request per byte (or palette write) and is busy until that byte
// is done. A palette write is taken in the idle state. A pixel byte passes
// accept, byte step and row count step, plus, for indexed depths, a palette
// read and an output load per emitted pixel. A 24/32-bit pixel without masks
// adds an output load. Masked pixels (5-5-5 or bitfields) run each of the
// four channels through one shared restoring divider: pick the mask, align
// it, then divide. A full output register stalls emission until the consumer
// takes it.
`default_nettype none

module bmp_pixel_row_decoder
    import bpd_pkg::*;
#(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input requests
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in_req     i_in,
    // output requests
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out_req         o_out,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RBW = WW + 3;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int PCW = PW + 1;

    localparam logic [WW-1:0]  MAXW     = WW'(MAX_WIDTH);
    localparam logic [RW-1:0]  ROW_LAST = RW'(MAX_HEIGHT - 1);
    localparam logic [PCW-1:0] PDEPTH   = PCW'(PALETTE_DEPTH);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BYTE = 4'd1;
    localparam logic [3:0] S_PIX  = 4'd2;
    localparam logic [3:0] S_POUT = 4'd3;
    localparam logic [3:0] S_CH   = 4'd4;
    localparam logic [3:0] S_NORM = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_DOUT = 4'd7;
    localparam logic [3:0] S_END  = 4'd8;

    // configuration registers
    logic [2:0]  r_depth;
    logic        r_bf;
    logic [31:0] r_mask_r, r_mask_g, r_mask_b, r_mask_a;
    logic [12:0] r_width;
    logic [8:0]  r_pcount;

    // control and datapath registers
    logic [3:0]     r_state;
    logic [7:0]     r_byte;
    logic [2:0]     r_k;
    logic [23:0]    r_asm;
    logic [1:0]     r_phase;
    logic [WW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [RBW-1:0] r_rbc;
    logic [31:0]    r_px;
    logic [1:0]     r_chan;
    logic [7:0]     r_ch [4];
    logic [31:0]    r_mask_w;
    logic [31:0]    r_val;
    logic [31:0]    r_rem;
    logic [39:0]    r_div;
    logic [7:0]     r_quo;
    logic [5:0]     r_cnt;
    logic           r_ovalid;
    t_out_req       r_out;

    // palette memory
    logic [23:0] r_pal [PALETTE_DEPTH];
    logic [23:0] r_pal_rd;

    // ------------------------------------------------------------------
    // Derived format values
    // ------------------------------------------------------------------
    logic           is_small, is_16, is_24;
    logic [1:0]     last_phase;
    logic [2:0]     last_k;
    logic [WW-1:0]  width;
    logic [WW+4:0]  row_bits;
    logic [RBW-1:0] row_bytes, padded;
    logic [PCW-1:0] pcount;

    always_comb begin
        is_small = (r_depth == DEPTH_1) || (r_depth == DEPTH_4) || (r_depth == DEPTH_8);
        is_16    = (r_depth == DEPTH_16);
        is_24    = (r_depth == DEPTH_24);
        if (r_depth == DEPTH_1) begin
            last_k = 3'd7;
        end else if (r_depth == DEPTH_4) begin
            last_k = 3'd1;
        end else begin
            last_k = 3'd0;
        end
        if (is_16) begin
            last_phase = 2'd1;
        end else if (is_24) begin
            last_phase = 2'd2;
        end else begin
            last_phase = 2'd3;
        end

        // width clamp: zero reads as one, beyond max reads as max
        if (r_width == 13'd0) begin
            width = WW'(1);
        end else if ({2'b00, r_width} > 15'(MAX_WIDTH)) begin
            width = MAXW;
        end else begin
            width = WW'(r_width);
        end

        // bits per row
        unique case (r_depth)
            DEPTH_1:  row_bits = (WW+5)'(width);
            DEPTH_4:  row_bits = (WW+5)'(width) << 2;
            DEPTH_8:  row_bits = (WW+5)'(width) << 3;
            DEPTH_16: row_bits = (WW+5)'(width) << 4;
            DEPTH_24: row_bits = ((WW+5)'(width) << 4) + ((WW+5)'(width) << 3);
            default:  row_bits = (WW+5)'(width) << 5;
        endcase
        row_bytes = RBW'((row_bits + (WW+5)'(7)) >> 3);
        padded    = (row_bytes + RBW'(3)) & ~RBW'(3);

        if ({{(PCW > 9 ? PCW - 9 : 0){1'b0}}, r_pcount} > PCW'(PALETTE_DEPTH)) begin
            pcount = PDEPTH;
        end else begin
            pcount = PCW'(r_pcount);
        end
    end

    // ------------------------------------------------------------------
    // Indexed pixel: palette index for the current sub-pixel
    // ------------------------------------------------------------------
    logic [7:0]    pix_idx;
    logic [PW-1:0] rd_addr;

    always_comb begin
        if (r_depth == DEPTH_8) begin
            pix_idx = r_byte;
        end else if (r_depth == DEPTH_4) begin
            pix_idx = (r_k == 3'd0) ? {4'h0, r_byte[7:4]} : {4'h0, r_byte[3:0]};
        end else begin
            pix_idx = {7'd0, r_byte[3'd7 - r_k]};
        end
        if ({{(PCW > 8 ? PCW - 8 : 0){1'b0}}, pix_idx} >= {{(PCW > 8 ? 0 : 8 - PCW){1'b0}},
                pcount}) begin
            rd_addr = '0;
        end else begin
            rd_addr = pix_idx[PW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Full pixel word and per-channel mask
    // ------------------------------------------------------------------
    logic [31:0] px_full;
    logic [31:0] ch_mask;
    logic        use_div;

    always_comb begin
        unique case (last_phase)
            2'd1:    px_full = {8'h00, r_asm} | {16'h0000, r_byte, 8'h00};
            2'd2:    px_full = {8'h00, r_asm} | {8'h00, r_byte, 16'h0000};
            default: px_full = {8'h00, r_asm} | {r_byte, 24'h000000};
        endcase
        use_div = (r_bf && !is_24) || is_16;
        if (r_bf) begin
            unique case (r_chan)
                2'd0:    ch_mask = r_mask_r;
                2'd1:    ch_mask = r_mask_g;
                2'd2:    ch_mask = r_mask_b;
                default: ch_mask = r_mask_a;
            endcase
        end else begin
            unique case (r_chan)
                2'd0:    ch_mask = MASK_555_RED;
                2'd1:    ch_mask = MASK_555_GREEN;
                2'd2:    ch_mask = MASK_555_BLUE;
                default: ch_mask = 32'd0;
            endcase
        end
    end

    // divider step
    logic [32:0] trial;
    logic        q_bit;
    logic [32:0] trial_sub;

    always_comb begin
        trial     = {r_rem, r_div[39]};
        trial_sub = trial - {1'b0, r_mask_w};
        q_bit     = (trial >= {1'b0, r_mask_w});
    end

    // output field helpers
    logic [WW+11:0] col_ext;
    logic [RW+11:0] row_ext;
    logic           slot_free;
    logic           col_in;
    logic           col_is_last;
    logic           out_load;

    always_comb begin
        col_ext     = {12'd0, r_col};
        row_ext     = {12'd0, r_row};
        slot_free   = !r_ovalid || i_ready;
        col_in      = r_col < width;
        col_is_last = ({1'b0, r_col} + (WW+1)'(1)) == {1'b0, width};
        out_load    = slot_free && ((r_state == S_POUT) || ((r_state == S_DOUT) && col_in));
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= DEPTH_32;
            r_bf     <= 1'b0;
            r_mask_r <= '0;
            r_mask_g <= '0;
            r_mask_b <= '0;
            r_mask_a <= '0;
            r_width  <= 13'd1;
            r_pcount <= 9'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEPTH_MODE:    r_depth  <= i_cfg_data[2:0];
                REG_USE_BITFIELDS: r_bf     <= i_cfg_data[0];
                REG_RED_MASK:      r_mask_r <= i_cfg_data;
                REG_GREEN_MASK:    r_mask_g <= i_cfg_data;
                REG_BLUE_MASK:     r_mask_b <= i_cfg_data;
                REG_ALPHA_MASK:    r_mask_a <= i_cfg_data;
                REG_IMAGE_WIDTH:   r_width  <= i_cfg_data[12:0];
                default:           r_pcount <= i_cfg_data[8:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Palette memory: write on palette request, registered read
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid && (i_in.opcode == OP_PALETTE) &&
                ({1'b0, i_in.palette_index} < 9'(PALETTE_DEPTH))) begin
            r_pal[i_in.palette_index[PW-1:0]] <= {i_in.palette_red, i_in.palette_green,
                                                  i_in.palette_blue};
        end
        if (r_state == S_PIX) begin
            r_pal_rd <= r_pal[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_asm    <= '0;
            r_phase  <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_rbc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // output register: load a new pixel, else drop the taken one
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && (i_in.opcode == OP_PIXEL)) begin
                        r_byte  <= i_in.byte_value;
                        r_state <= S_BYTE;
                        if (i_in.start_of_image) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_rbc   <= '0;
                            r_phase <= '0;
                            r_asm   <= '0;
                        end
                    end
                end
                S_BYTE: begin
                    r_k    <= '0;
                    r_chan <= '0;
                    if (r_rbc >= row_bytes) begin
                        r_state <= S_END;
                    end else if (is_small) begin
                        r_state <= col_in ? S_PIX : S_END;
                    end else if (r_phase < last_phase) begin
                        unique case (r_phase)
                            2'd0:    r_asm <= r_asm | {16'h0000, r_byte};
                            2'd1:    r_asm <= r_asm | {8'h00, r_byte, 8'h00};
                            default: r_asm <= r_asm | {r_byte, 16'h0000};
                        endcase
                        r_phase <= r_phase + 2'd1;
                        r_state <= S_END;
                    end else begin
                        r_px    <= px_full;
                        r_asm   <= '0;
                        r_phase <= '0;
                        if (use_div) begin
                            r_state <= S_CH;
                        end else begin
                            r_ch[0] <= px_full[23:16];
                            r_ch[1] <= px_full[15:8];
                            r_ch[2] <= px_full[7:0];
                            r_ch[3] <= is_24 ? 8'hFF : px_full[31:24];
                            r_state <= S_DOUT;
                        end
                    end
                end
                S_PIX: begin
                    r_state <= S_POUT;
                end
                S_POUT: begin
                    if (slot_free) begin
                        r_out.red          <= r_pal_rd[23:16];
                        r_out.green        <= r_pal_rd[15:8];
                        r_out.blue         <= r_pal_rd[7:0];
                        r_out.alpha        <= 8'hFF;
                        r_out.column       <= col_ext[11:0];
                        r_out.row          <= row_ext[11:0];
                        r_out.row_end      <= col_is_last;
                        r_out.last_of_item <= (r_k == last_k) || col_is_last;
                        r_col              <= r_col + WW'(1);
                        r_k                <= r_k + 3'd1;
                        if ((r_k == last_k) || col_is_last) begin
                            r_state <= S_END;
                        end else begin
                            r_state <= S_PIX;
                        end
                    end
                end
                // pick the channel mask; zero mask settles the channel at once
                S_CH: begin
                    if (ch_mask == 32'd0) begin
                        r_ch[r_chan] <= (r_chan == 2'd3) ? 8'hFF : 8'h00;
                        r_chan       <= r_chan + 2'd1;
                        if (r_chan == 2'd3) begin
                            r_state <= S_DOUT;
                        end
                    end else begin
                        r_mask_w <= ch_mask;
                        r_val    <= r_px & ch_mask;
                        r_state  <= S_NORM;
                    end
                end
                // align mask and value to the mask's lowest set bit
                S_NORM: begin
                    if (!r_mask_w[0]) begin
                        r_mask_w <= r_mask_w >> 1;
                        r_val    <= r_val >> 1;
                    end else begin
                        r_div   <= {r_val, 8'h00} - {8'h00, r_val};
                        r_rem   <= '0;
                        r_cnt   <= 6'd40;
                        r_state <= S_DIV;
                    end
                end
                // restoring divide, one quotient bit per cycle
                S_DIV: begin
                    if (r_cnt == 6'd0) begin
                        r_ch[r_chan] <= r_quo;
                        r_chan       <= r_chan + 2'd1;
                        r_state      <= (r_chan == 2'd3) ? S_DOUT : S_CH;
                    end else begin
                        r_rem <= q_bit ? trial_sub[31:0] : trial[31:0];
                        r_div <= {r_div[38:0], 1'b0};
                        r_quo <= {r_quo[6:0], q_bit};
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_DOUT: begin
                    if (!col_in) begin
                        r_state <= S_END;
                    end else if (slot_free) begin
                        r_out.red          <= r_ch[0];
                        r_out.green        <= r_ch[1];
                        r_out.blue         <= r_ch[2];
                        r_out.alpha        <= r_ch[3];
                        r_out.column       <= col_ext[11:0];
                        r_out.row          <= row_ext[11:0];
                        r_out.row_end      <= col_is_last;
                        r_out.last_of_item <= 1'b1;
                        r_col              <= r_col + WW'(1);
                        r_state            <= S_END;
                    end
                end
                // advance the row byte count, drop padding at row end
                S_END: begin
                    r_state <= S_IDLE;
                    if ((r_rbc + RBW'(1)) >= padded) begin
                        r_rbc   <= '0;
                        r_col   <= '0;
                        r_phase <= '0;
                        r_asm   <= '0;
                        r_row   <= (r_row == ROW_LAST) ? '0 : r_row + RW'(1);
                    end else begin
                        r_rbc <= r_rbc + RBW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
